/* sv/sqr_pkg.sv */
// ----------------------------------------------------------------------------
// sqr_pkg: shared types and codes for the shifting queue
// Operation and status codes, the cell command set and the controller state.
// ----------------------------------------------------------------------------
package sqr_pkg;

    localparam int DATA_W    = 32;
    localparam int OUT_POS_W = 4;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ENQ,
        CMD_DEQ,
        CMD_REMOVE,
        CMD_ROTATE
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_ROTATE
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [DATA_W-1:0]  value;
    } t_cell_ctl;

endpackage

/* sv/shifting_queue_with_remove_by_value.sv */
// ----------------------------------------------------------------------------
// shifting_queue_with_remove_by_value: packed queue with remove-by-value
// A row of DEPTH cells kept packed from slot 0, with enqueue, dequeue and
// removal of the first entry equal to a given value.
// ----------------------------------------------------------------------------
// Every beat's result is registered for the output channel. A remove that
// finds its value at slot p > 0 closes the gap in the cycle it is taken and
// then rotates the row by one slot per cycle until the entries after the match
// come first; no input beat is taken during the rotation. It moves one slot at
// a time because the cell row has the single neighbor-to-neighbor shift path.
// Entries start undefined; only slots below the count are ever compared or
// read.
// ----------------------------------------------------------------------------
module shifting_queue_with_remove_by_value #(
    parameter int DEPTH = sqr_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic signed [sqr_pkg::DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [CNT_W-1:0]              o_count,
    output logic signed [sqr_pkg::DATA_W-1:0] o_value_out,
    output logic [sqr_pkg::OUT_POS_W-1:0] o_position
);
    import sqr_pkg::*;

    localparam int POS_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [POS_W-1:0]    r_rot, n_rot;
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [CNT_W-1:0]    r_o_count, n_o_count;
    logic [DATA_W-1:0]   r_value_out, n_value_out;
    logic [OUT_POS_W-1:0] r_position, n_position;

    t_cell_ctl           w_ctl;
    logic                w_accept;
    logic [DATA_W-1:0]   w_data  [DEPTH];
    logic                w_found [DEPTH+1];
    logic                w_first [DEPTH];
    logic [POS_W-1:0]    w_pos;
    logic [OUT_POS_W-1:0] w_pos_out;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        sqr_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_next  (w_next),
            .i_head  (w_data[0]),
            .i_found (w_found[g]),
            .o_data  (w_data[g]),
            .o_found (w_found[g+1]),
            .o_first (w_first[g])
        );
    end

    // encode the single first-match slot
    always_comb begin
        w_pos     = '0;
        w_pos_out = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_first[k]) begin
                w_pos     = w_pos | POS_W'(k);
                w_pos_out = w_pos_out | OUT_POS_W'(k);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_rot   = r_rot;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (t_op'(i_op) == OP_REMOVE) && w_found[DEPTH]
                        && (w_pos != '0)) begin
                    n_state = S_ROTATE;
                    n_rot   = w_pos;
                end
            end
            S_ROTATE: begin
                n_rot = r_rot - POS_W'(1);
                if (r_rot == POS_W'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell command, count and result
    always_comb begin
        w_ctl.value = i_value;
        w_ctl.cmd   = (r_state == S_ROTATE) ? CMD_ROTATE : CMD_HOLD;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_o_count   = r_o_count;
        n_value_out = r_value_out;
        n_position  = r_position;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_value_out = '0;
            n_position  = '0;
            unique case (t_op'(i_op))
                OP_ENQ: begin
                    if (r_count == FULL_CNT) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.cmd = CMD_ENQ;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                OP_DEQ: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.cmd   = CMD_DEQ;
                        n_count     = r_count - CNT_W'(1);
                        n_value_out = w_data[0];
                    end
                end
                OP_REMOVE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (!w_found[DEPTH]) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        w_ctl.cmd   = CMD_REMOVE;
                        n_count     = r_count - CNT_W'(1);
                        n_value_out = i_value;
                        n_position  = w_pos_out;
                    end
                end
                OP_NONE: n_status = ST_OK;
                default: n_status = ST_OK;
            endcase
            n_o_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rot       <= n_rot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_o_count   <= n_o_count;
        r_value_out <= n_value_out;
        r_position  <= n_position;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_count     = r_o_count;
    assign o_value_out = r_value_out;
    assign o_position  = r_position;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_count_moves_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("entry count changed without an input beat");

    a_rotate_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROTATE) |-> !o_in_ready)
        else $error("input taken during rotation");

    a_rotate_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROTATE) |-> (r_rot != '0) && (r_count != '0))
        else $error("rotation with no steps left or empty row");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_pos_out) <= OUT_POS_W && (w_found[DEPTH] || w_pos == '0))
        else $error("match position without a match");

endmodule

/* sv/sqr_cell.sv */
// ----------------------------------------------------------------------------
// sqr_cell: one slot of the shifting queue
// Holds one entry, compares it against the search value and takes data from
// the input, its right-hand neighbor or the head as the command asks.
// ----------------------------------------------------------------------------
module sqr_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                      i_clk,
    input  sqr_pkg::t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0]          i_count,
    input  logic [sqr_pkg::DATA_W-1:0] i_next,
    input  logic [sqr_pkg::DATA_W-1:0] i_head,
    input  logic                      i_found,
    output logic [sqr_pkg::DATA_W-1:0] o_data,
    output logic                      o_found,
    output logic                      o_first
);
    import sqr_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_IDX1 = CNT_W'(IDX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_valid;
    logic              w_match;

    assign w_valid = MY_IDX < i_count;
    assign w_match = w_valid && (r_data == i_ctl.value);
    assign o_found = i_found | w_match;
    assign o_first = w_match & ~i_found;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.cmd)
            CMD_HOLD:   n_data = r_data;
            CMD_ENQ:    if (MY_IDX == i_count) n_data = i_ctl.value;
            CMD_DEQ:    n_data = i_next;
            // close the gap from the match onward
            CMD_REMOVE: if (o_found) n_data = i_next;
            // move the head to the tail, the rest one slot forward
            CMD_ROTATE: n_data = (MY_IDX1 == i_count) ? i_head : i_next;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
